// ===== src/zdr_pkg.sv =====
package zdr_pkg;

  localparam int MAX_ROWS    = 8;
  localparam int MAX_COLS    = 8;
  localparam int DATA_W      = 32;
  localparam int DIM_W       = 4;
  localparam int CNT_W       = 7;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CFG_IDX_W   = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS = 1'b0,
    CFG_COLS = 1'b1
  } cfg_idx_t;

  // one readout request, sizes already clamped
  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } ram_rd_t;

  typedef struct packed {
    logic walking;
    logic rd_pend;
  } back_stat_t;

  // zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [DIM_W-1:0] clamp_size(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (v > maxv) begin
      res = maxv;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

// ===== src/zdr_ram.sv =====
module zdr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/zdr_front.sv =====
module zdr_front
  import zdr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [DATA_W-1:0]    in_tdata,
  input  logic                 in_tlast,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic                 fifo_full,
  input  logic                 fifo_not_empty,
  input  back_stat_t           back_stat,
  output logic                 job_push,
  output job_t                 job,
  output ram_wr_t              ram_wr
);

  logic [DIM_W-1:0] rows_r, rows_nxt;
  logic [DIM_W-1:0] cols_r, cols_nxt;
  logic [CNT_W-1:0] wcnt_r, wcnt_nxt;
  logic             hold_r, hold_nxt;
  logic [DIM_W-1:0] rows_c, cols_c;
  logic [CNT_W-1:0] total;
  logic             accept;
  logic             room;

  assign rows_c    = clamp_size(rows_r, DIM_W'(MAX_ROWS));
  assign cols_c    = clamp_size(cols_r, DIM_W'(MAX_COLS));
  assign total     = CNT_W'(rows_c * cols_c);
  assign in_tready = !hold_r && !fifo_full;
  assign accept    = in_tvalid && in_tready;
  assign room      = wcnt_r < total;

  assign ram_wr.en   = accept && room;
  assign ram_wr.addr = wcnt_r[ADDR_W-1:0];
  assign ram_wr.data = in_tdata;

  assign job_push = accept && in_tlast;
  assign job.rows = rows_c;
  assign job.cols = cols_c;

  always_comb begin
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ROWS: rows_nxt = cfg_data;
        CFG_COLS: cols_nxt = cfg_data;
        default:  ;
      endcase
    end
  end

  always_comb begin
    wcnt_nxt = wcnt_r;
    hold_nxt = hold_r;
    if (accept) begin
      if (in_tlast) begin
        wcnt_nxt = '0;
      end else if (room) begin
        wcnt_nxt = wcnt_r + CNT_W'(1);
      end
    end
    // keep the store frozen until every read of the readout is issued
    if (job_push) begin
      hold_nxt = 1'b1;
    end else if (hold_r && !fifo_not_empty && !back_stat.walking) begin
      hold_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= DIM_W'(MAX_ROWS);
      cols_r <= DIM_W'(MAX_COLS);
      wcnt_r <= '0;
      hold_r <= 1'b0;
    end else begin
      rows_r <= rows_nxt;
      cols_r <= cols_nxt;
      wcnt_r <= wcnt_nxt;
      hold_r <= hold_nxt;
    end
  end

endmodule

// ===== src/zdr_job_fifo.sv =====
module zdr_job_fifo
  import zdr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head_job,
  output logic not_empty,
  output logic full
);

  job_t       slot_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign head_job  = slot_r[rptr_r];
  assign not_empty = cnt_r != 2'd0;
  assign full      = cnt_r == 2'd2;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !full) begin
      wptr_nxt = !wptr_r;
      cnt_nxt  = cnt_nxt + 2'd1;
    end
    if (pop && not_empty) begin
      rptr_nxt = !rptr_r;
      cnt_nxt  = cnt_nxt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_r[wptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ===== src/zdr_back.sv =====
module zdr_back
  import zdr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  input  job_t              job,
  output logic              job_pop,
  output ram_rd_t           ram_rd,
  input  logic [DATA_W-1:0] rd_data,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,
  output logic              out_tlast,
  output back_stat_t        back_stat
);

  localparam int RC_W = $clog2(MAX_ROWS > MAX_COLS ? MAX_ROWS : MAX_COLS) + 1;

  logic [DIM_W-1:0]  rows_r, rows_nxt;
  logic [DIM_W-1:0]  cols_r, cols_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [RC_W-1:0]   row_r, row_nxt;
  logic [RC_W-1:0]   col_r, col_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic              up_r, up_nxt;
  logic              walk_r, walk_nxt;
  logic              rd_pend_r;
  logic              rd_last_r;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic              out_last_r, out_last_nxt;
  logic              issue;
  logic              is_last;
  logic              at_right, at_top, at_bottom, at_left;
  logic [CNT_W-1:0]  a_ext, c_ext;

  assign issue     = walk_r && !rd_pend_r && (!out_valid_r || out_tready);
  assign is_last   = (k_r + CNT_W'(1)) == total_r;
  assign job_pop   = job_valid && !walk_r;
  assign at_right  = DIM_W'(col_r) == (cols_r - DIM_W'(1));
  assign at_bottom = DIM_W'(row_r) == (rows_r - DIM_W'(1));
  assign at_top    = row_r == '0;
  assign at_left   = col_r == '0;
  assign a_ext     = CNT_W'(addr_r);
  assign c_ext     = CNT_W'(cols_r);

  assign ram_rd.en   = issue;
  assign ram_rd.addr = addr_r;

  // walk the anti-diagonals, one position per issued read
  always_comb begin
    rows_nxt  = rows_r;
    cols_nxt  = cols_r;
    total_nxt = total_r;
    k_nxt     = k_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    addr_nxt  = addr_r;
    up_nxt    = up_r;
    walk_nxt  = walk_r;
    if (job_pop) begin
      rows_nxt  = job.rows;
      cols_nxt  = job.cols;
      total_nxt = CNT_W'(job.rows * job.cols);
      k_nxt     = '0;
      row_nxt   = '0;
      col_nxt   = '0;
      addr_nxt  = '0;
      up_nxt    = 1'b1;
      walk_nxt  = 1'b1;
    end else if (issue) begin
      k_nxt = k_r + CNT_W'(1);
      if (is_last) begin
        walk_nxt = 1'b0;
      end
      if (up_r) begin
        if (at_right) begin
          row_nxt  = row_r + RC_W'(1);
          addr_nxt = ADDR_W'(a_ext + c_ext);
          up_nxt   = 1'b0;
        end else if (at_top) begin
          col_nxt  = col_r + RC_W'(1);
          addr_nxt = addr_r + ADDR_W'(1);
          up_nxt   = 1'b0;
        end else begin
          row_nxt  = row_r - RC_W'(1);
          col_nxt  = col_r + RC_W'(1);
          addr_nxt = ADDR_W'(a_ext - c_ext + CNT_W'(1));
        end
      end else begin
        if (at_bottom) begin
          col_nxt  = col_r + RC_W'(1);
          addr_nxt = addr_r + ADDR_W'(1);
          up_nxt   = 1'b1;
        end else if (at_left) begin
          row_nxt  = row_r + RC_W'(1);
          addr_nxt = ADDR_W'(a_ext + c_ext);
          up_nxt   = 1'b1;
        end else begin
          row_nxt  = row_r + RC_W'(1);
          col_nxt  = col_r - RC_W'(1);
          addr_nxt = ADDR_W'(a_ext + c_ext - CNT_W'(1));
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (rd_pend_r) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = rd_data;
      out_last_nxt  = rd_last_r;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rows_r     <= rows_nxt;
    cols_r     <= cols_nxt;
    total_r    <= total_nxt;
    k_r        <= k_nxt;
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    addr_r     <= addr_nxt;
    up_r       <= up_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    if (issue) begin
      rd_last_r <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_r      <= 1'b0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      walk_r      <= walk_nxt;
      rd_pend_r   <= issue;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid        = out_valid_r;
  assign out_tdata         = out_data_r;
  assign out_tlast         = out_last_r;
  assign back_stat.walking = walk_r;
  assign back_stat.rd_pend = rd_pend_r;

endmodule

// ===== src/zigzag_diagonal_reorder_core.sv =====
// Zigzag diagonal reorder core.
// Input stream (in_*): matrix elements in row-major order, one item per
// element; in_tlast marks the final element and starts the readout. Elements
// past rows*cols are dropped. Output stream (out_*): the whole matrix in zigzag
// anti-diagonal order, starting top-left and heading up-right first;
// out_tlast flags the final item of a readout.
// Config port (cfg_*): index 0 sets rows, index 1 sets cols (1..8; zero acts
// as one, larger values as eight). cfg_ready is always high. Write it only
// while the core is idle; sizes in force at the marked element apply.
// Timing: while collecting, one input item per cycle. After the marked item
// is accepted, the job passes through the job queue to the walker, which
// issues a single store read at a time and waits for the registered read
// data to land in the output register before issuing the next.
// in_tready stays low from the marked item until the last store read of the
// readout is issued and the walker's busy flag and then the front's hold
// register have cleared; a stalling receiver delays this.
// A stalled receiver holds the output register and pauses the walk; nothing
// is lost. Reset (rst_n low, synchronous) empties the job queue, drops any
// readout in progress, zeroes the element count and sets both sizes to 8.
// Store contents are not cleared.
module zigzag_diagonal_reorder_core
  import zdr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [DATA_W-1:0]    in_tdata,   // [31:0] element_value
  input  logic                 in_tlast,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [DATA_W-1:0]    out_tdata,  // [31:0] element_out
  output logic                 out_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  logic              job_push;
  job_t              push_job;
  job_t              head_job;
  logic              job_pop;
  logic              fifo_not_empty;
  logic              fifo_full;
  ram_wr_t           ram_wr;
  ram_rd_t           ram_rd;
  logic [DATA_W-1:0] rd_data;
  back_stat_t        back_stat;

  assign cfg_ready = 1'b1;

  // front: take elements, fill the store, queue a readout on the mark
  zdr_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fifo_full      (fifo_full),
    .fifo_not_empty (fifo_not_empty),
    .back_stat      (back_stat),
    .job_push       (job_push),
    .job            (push_job),
    .ram_wr         (ram_wr)
  );

  zdr_job_fifo u_job_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_job  (push_job),
    .pop       (job_pop),
    .head_job  (head_job),
    .not_empty (fifo_not_empty),
    .full      (fifo_full)
  );

  // matrix store: one write port for the front, one read port for the back
  zdr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr.en),
    .wr_addr (ram_wr.addr),
    .wr_data (ram_wr.data),
    .rd_en   (ram_rd.en),
    .rd_addr (ram_rd.addr),
    .rd_data (rd_data)
  );

  // back: walk the zigzag and drive the result stream
  zdr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (fifo_not_empty),
    .job        (head_job),
    .job_pop    (job_pop),
    .ram_rd     (ram_rd),
    .rd_data    (rd_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .back_stat  (back_stat)
  );

  // the store must not take new elements while a readout is walking
  a_no_write_during_walk: assert property (@(posedge clk) disable iff (!rst_n)
    back_stat.walking |-> !in_tready)
    else $error("input open while readout walks");

  // a marked item closes the input
  a_hold_after_mark: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input still open after marked item");

  // the job queue never overflows
  a_fifo_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> !fifo_full)
    else $error("job queue overflow");

  // read data always lands in an empty output register
  a_out_free_for_read: assert property (@(posedge clk) disable iff (!rst_n)
    back_stat.rd_pend |-> !out_tvalid)
    else $error("store read returned while output register busy");

endmodule
